// ===== rtl/core/mlfq_pkg.sv =====
// Shared types, codes and constants for the multilevel feedback queue scheduler.
// No dependencies; every other source file but mlfq_checker imports this package.
`default_nettype none
package mlfq_pkg;
    localparam int unsigned NUM_SLOTS_DEF = 64;
    localparam int unsigned TICK_W = 16;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [1:0] ACT_SET = 2'd0;
    localparam logic [1:0] ACT_DISPATCH = 2'd1;
    localparam logic [1:0] ACT_REPORT = 2'd2;
    localparam logic [1:0] ACT_BOOST = 2'd3;

    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_RUNNING = 3'd4;
    localparam logic [2:0] ST_ZOMBIE = 3'd5;

    localparam logic [1:0] TOP_PRIO = 2'd3;
    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_P1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_P2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_P3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_P0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_P1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_P2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_P3 = 3'd6;

    // One queued command between the front and back parts.
    typedef struct packed {
        logic [1:0]        action;
        logic [5:0]        slot;
        logic [2:0]        status;
        logic              fresh;
        logic [TICK_W-1:0] ticks;
    } t_cmd;
endpackage
`default_nettype wire

// ===== rtl/core/mlfq_process_scheduler_top.sv =====
// Top level of the multilevel feedback queue scheduler.
// Depends on mlfq_pkg, mlfq_front and mlfq_back.
`default_nettype none
// One result per transaction. A dispatch scans the slot table one entry per cycle
// through the memory read port; a run report includes a restoring remainder of the
// tick count by the quantum, in sixteen steps. A two-entry queue lets transactions
// arrive while the back part is busy.
module mlfq_process_scheduler_top #(
    parameter int unsigned NUM_SLOTS = mlfq_pkg::NUM_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [5:0]  i_slot,
    input  wire logic [2:0]  i_new_status,
    input  wire logic        i_fresh,
    input  wire logic [15:0] i_ticks_run,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_granted,
    output logic [5:0]       o_chosen_slot,
    output logic [1:0]       o_chosen_priority,
    input  wire logic        i_cfg_we,
    input  wire logic [mlfq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import mlfq_pkg::*;

    t_cmd in_cmd, q_cmd;
    logic q_valid, q_take;

    assign in_cmd = '{action: i_action, slot: i_slot, status: i_new_status,
                      fresh: i_fresh, ticks: i_ticks_run};

    mlfq_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_cmd(in_cmd),
        .o_cmd_valid(q_valid), .o_cmd(q_cmd), .i_cmd_take(q_take)
    );

    mlfq_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(q_valid), .i_cmd(q_cmd), .o_cmd_take(q_take),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_valid, .i_stall,
        .o_granted, .o_chosen_slot, .o_chosen_priority
    );
endmodule
`default_nettype wire

// ===== rtl/core/mlfq_front.sv =====
// Front part: accepts transactions into a two-entry command queue.
// Depends on mlfq_pkg.
`default_nettype none
module mlfq_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire mlfq_pkg::t_cmd i_cmd,
    output logic               o_cmd_valid,
    output mlfq_pkg::t_cmd     o_cmd,
    input  wire logic          i_cmd_take
);
    import mlfq_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign pop         = i_cmd_take && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Queue payload.
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

// ===== rtl/core/mlfq_back.sv =====
// Back part: slot table, dispatch scan, run reports and boost.
// Depends on mlfq_pkg.
`default_nettype none
module mlfq_back #(
    parameter int unsigned NUM_SLOTS = mlfq_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cmd_valid,
    input  wire mlfq_pkg::t_cmd          i_cmd,
    output logic                         o_cmd_take,
    input  wire logic                    i_cfg_we,
    input  wire logic [mlfq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mlfq_pkg::TICK_W-1:0]    i_cfg_data,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic                         o_granted,
    output logic [5:0]                   o_chosen_slot,
    output logic [1:0]                   o_chosen_priority
);
    import mlfq_pkg::*;

    localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
    localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_PICK = 4'd2;
    localparam logic [3:0] S_REP1 = 4'd3;
    localparam logic [3:0] S_REP2 = 4'd4;
    localparam logic [3:0] S_REP3 = 4'd5;
    localparam logic [3:0] S_REP4 = 4'd6;
    localparam logic [3:0] S_BOOST = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;
    localparam logic [3:0] S_REP5 = 4'd9;

    // Slot table held as three memories (priority and ticks via valid epoch bits).
    logic [2:0]        m_status [NUM_SLOTS];
    logic [1:0]        m_prio   [NUM_SLOTS];
    logic [TICK_W-1:0] m_ticks  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_stv, r_ptv;  // entry written since reset / boost

    logic [TICK_W-1:0] r_lim [1:3];
    logic [TICK_W-1:0] r_qnt [4];

    logic [3:0]  r_state;
    t_cmd        r_cmd;
    logic [IW-1:0] r_prev, r_run, r_idx, r_best;
    logic [CW-1:0] r_cnt;
    logic        r_found;
    logic [1:0]  r_bprio;
    logic [2:0]  r_rd_st;
    logic [1:0]  r_rd_pr;
    logic [TICK_W-1:0] r_rd_tk, r_tk, r_rem;
    logic [2*TICK_W-2:0] r_qs;
    logic [4:0]  r_dcnt;
    logic [1:0]  r_pr;
    logic        r_granted;
    logic [5:0]  r_cslot;
    logic [1:0]  r_cprio;

    // Memory read address and registered read.
    logic [IW-1:0] rd_addr;
    always_comb begin
        rd_addr = r_idx;
    end
    always_ff @(posedge i_clk) begin
        r_rd_st <= r_stv[rd_addr] ? m_status[rd_addr] : 3'd0;
        r_rd_pr <= r_ptv[rd_addr] ? m_prio[rd_addr] : TOP_PRIO;
        r_rd_tk <= r_ptv[rd_addr] ? m_ticks[rd_addr] : '0;
    end

    assign o_cmd_take        = (r_state == S_IDLE) && i_cmd_valid;
    assign o_valid           = (r_state == S_OUT);
    assign o_granted         = r_granted;
    assign o_chosen_slot     = r_cslot;
    assign o_chosen_priority = r_cprio;

    logic [IW-1:0] idx_nx;
    assign idx_nx = (r_idx == LAST) ? '0 : r_idx + 1'b1;

    logic [TICK_W:0] tsum;
    assign tsum = {1'b0, r_rd_tk} + {1'b0, r_cmd.ticks};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim[1] <= 16'd32; r_lim[2] <= 16'd16; r_lim[3] <= 16'd8;
            r_qnt[0] <= 16'd32; r_qnt[1] <= 16'd8;
            r_qnt[2] <= 16'd4;  r_qnt[3] <= 16'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIMIT_P1: r_lim[1] <= i_cfg_data;
                CFG_LIMIT_P2: r_lim[2] <= i_cfg_data;
                CFG_LIMIT_P3: r_lim[3] <= i_cfg_data;
                CFG_QUANT_P0: r_qnt[0] <= i_cfg_data;
                CFG_QUANT_P1: r_qnt[1] <= i_cfg_data;
                CFG_QUANT_P2: r_qnt[2] <= i_cfg_data;
                CFG_QUANT_P3: r_qnt[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: one command at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stv   <= '0;
            r_ptv   <= '0;
            r_prev  <= LAST;
            r_run   <= '0;
            r_idx   <= '0;
            r_granted <= 1'b0;
            r_cslot <= '0;
            r_cprio <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_granted <= 1'b0;
                        r_cslot <= '0;
                        r_cprio <= '0;
                        unique case (i_cmd.action)
                            ACT_SET: begin
                                if (32'(i_cmd.slot) < NUM_SLOTS) begin
                                    m_status[IW'(i_cmd.slot)] <= i_cmd.status;
                                    r_stv[IW'(i_cmd.slot)] <= 1'b1;
                                    if (i_cmd.fresh) begin
                                        m_prio[IW'(i_cmd.slot)] <= TOP_PRIO;
                                        m_ticks[IW'(i_cmd.slot)] <= '0;
                                        r_ptv[IW'(i_cmd.slot)] <= 1'b1;
                                    end
                                end
                                r_state <= S_OUT;
                            end
                            ACT_DISPATCH: begin
                                r_idx <= (r_prev == LAST) ? '0 : r_prev + 1'b1;
                                r_cnt <= '0;
                                r_found <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            ACT_REPORT: begin
                                r_idx <= r_run;
                                r_state <= S_REP1;
                            end
                            default: begin
                                r_ptv <= '0;
                                r_state <= S_BOOST;
                            end
                        endcase
                    end
                end
                // Read address issued; data appears next cycle, one slot per cycle.
                // The slots after the previous pick are candidates; the last read is
                // the previous pick itself, taken only when nothing else was found.
                S_SCAN: begin
                    r_idx <= idx_nx;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt != '0 && r_cnt != CW'(NUM_SLOTS) &&
                        r_rd_st == ST_RUNNABLE &&
                        (!r_found || r_rd_pr > r_bprio)) begin
                        r_found <= 1'b1;
                        r_best  <= (r_idx == '0) ? LAST : r_idx - 1'b1;
                        r_bprio <= r_rd_pr;
                    end else if (r_cnt == CW'(NUM_SLOTS) && !r_found &&
                                 r_rd_st == ST_RUNNABLE) begin
                        r_found <= 1'b1;
                        r_best  <= r_prev;
                        r_bprio <= r_rd_pr;
                    end
                    if (r_cnt == CW'(NUM_SLOTS)) begin
                        r_state <= S_PICK;
                    end
                end
                // Mark the chosen slot running.
                S_PICK: begin
                    if (r_found) begin
                        m_status[r_best] <= ST_RUNNING;
                        r_stv[r_best] <= 1'b1;
                        r_run <= r_best;
                        r_granted <= 1'b1;
                        r_cslot <= 6'(r_best);
                        r_cprio <= r_bprio;
                    end
                    r_state <= S_OUT;
                end
                S_REP1: r_state <= S_REP2;
                // Update running slot status and ticks.
                S_REP2: begin
                    m_status[r_run] <= r_cmd.status;
                    r_stv[r_run] <= 1'b1;
                    if (r_cmd.status == ST_ZOMBIE) begin
                        r_tk <= '0;
                        r_pr <= TOP_PRIO;
                        r_qs <= {16'd1, 15'd0};
                        r_rem <= '0;
                    end else begin
                        r_tk <= tsum[TICK_W] ? TICK_MAX : tsum[TICK_W-1:0];
                        r_pr <= r_rd_pr;
                        r_qs <= {((r_qnt[r_rd_pr] == '0) ? 16'd1 : r_qnt[r_rd_pr]), 15'd0};
                        r_rem <= tsum[TICK_W] ? TICK_MAX : tsum[TICK_W-1:0];
                    end
                    r_dcnt <= '0;
                    r_state <= S_REP5;
                end
                // Restoring remainder: one shifted quantum per cycle, sixteen steps.
                S_REP5: begin
                    if (r_dcnt == 5'd16) begin
                        m_prio[r_run] <= r_pr;
                        m_ticks[r_run] <= r_tk;
                        r_ptv[r_run] <= 1'b1;
                        if (r_cmd.status != ST_SLEEPING && r_rem == '0) begin
                            r_prev <= r_run;
                            r_idx <= r_run;
                        end else begin
                            r_idx <= r_prev;
                        end
                        r_state <= S_REP3;
                    end else begin
                        if ({15'd0, r_rem} >= r_qs) r_rem <= r_rem - r_qs[TICK_W-1:0];
                        r_qs <= r_qs >> 1;
                        r_dcnt <= r_dcnt + 5'd1;
                    end
                end
                S_REP3: r_state <= S_REP4;
                // Demote candidate.
                S_REP4: begin
                    if (r_rd_pr != 2'd0 && r_rd_tk >= r_lim[r_rd_pr]) begin
                        m_prio[r_idx] <= r_rd_pr - 2'd1;
                        m_ticks[r_idx] <= '0;
                        r_ptv[r_idx] <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_BOOST: r_state <= S_OUT;
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/mlfq_checker.sv =====
// Port-level checks for the scheduler top level, bound to it below.
// Depends on no package; its ports are plain logic.
`default_nettype none
module mlfq_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_granted,
    input wire logic [5:0] o_chosen_slot,
    input wire logic [1:0] o_chosen_priority
);
    // A result without a grant carries zero fields.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_granted) |-> (o_chosen_slot == 6'd0 && o_chosen_priority == 2'd0))
        else $error("ungranted result has nonzero fields");
    // A stalled result stays.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_chosen_slot) && $stable(o_granted)))
        else $error("stalled result changed");
    // Results are separated: a taken result is not followed by another at once.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("back to back results");
endmodule

bind mlfq_process_scheduler_top mlfq_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_granted, .o_chosen_slot, .o_chosen_priority
);
`default_nettype wire

// ===== test/tb_mlfq_process_scheduler_top.sv =====
// Self-checking testbench for mlfq_process_scheduler_top.
// Depends on mlfq_pkg and the scheduler RTL; predicts every result in-line.
`default_nettype none
module tb_mlfq_process_scheduler_top;
    import mlfq_pkg::*;

    localparam int SLOTS = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  slot;
        logic [2:0]  status;
        logic        fresh;
        logic [15:0] ticks;
    } sched_cmd_t;

    typedef struct packed {
        logic       granted;
        logic [5:0] slot;
        logic [1:0] prio;
    } grant_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [5:0]  i_slot;
    logic [2:0]  i_new_status;
    logic        i_fresh;
    logic [15:0] i_ticks_run;
    logic        o_valid;
    logic        i_stall;
    logic        o_granted;
    logic [5:0]  o_chosen_slot;
    logic [1:0]  o_chosen_priority;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0] i_cfg_data;

    mlfq_process_scheduler_top dut (.*);

    // Shadow copy of the scheduler table and its settings.
    logic [2:0]  sh_status[SLOTS];
    logic [1:0]  sh_prio[SLOTS];
    logic [15:0] sh_ticks[SLOTS];
    logic [5:0]  sh_prev_pick;
    logic [5:0]  sh_running;
    logic [15:0] sh_limit[4];
    logic [15:0] sh_quantum[4];

    sched_cmd_t cmd_queue[$];
    grant_t     grant_queue[$];
    int         accepted_cnt;
    int         cycle_cnt;
    int         errors;
    bit         quiet;
    int         send_gap;
    int         recv_gap;
    int         hold_left;
    bit         hold_done;
    int         tick_cap;
    bit         allow_huge;

    // Apply one transaction to the shadow table and return the grant it causes.
    function automatic grant_t schedule_step(sched_cmd_t c);
        grant_t g;
        logic [5:0]  best;
        logic [5:0]  idx;
        logic [5:0]  r;
        logic [5:0]  cand;
        logic [1:0]  p;
        logic [16:0] sum;
        logic [15:0] q;
        bit found;
        g = '0;
        found = 0;
        best = '0;
        case (c.action)
            ACT_SET: begin
                sh_status[c.slot] = c.status;
                if (c.fresh) begin
                    sh_ticks[c.slot] = '0;
                    sh_prio[c.slot] = TOP_PRIO;
                end
            end
            ACT_DISPATCH: begin
                for (int i = 1; i < SLOTS; i++) begin
                    idx = sh_prev_pick + 6'(i);
                    if (sh_status[idx] == ST_RUNNABLE &&
                        (!found || sh_prio[idx] > sh_prio[best])) begin
                        best = idx;
                        found = 1;
                    end
                end
                if (!found && sh_status[sh_prev_pick] == ST_RUNNABLE) begin
                    best = sh_prev_pick;
                    found = 1;
                end
                if (found) begin
                    sh_status[best] = ST_RUNNING;
                    sh_running = best;
                    g.granted = 1'b1;
                    g.slot = best;
                    g.prio = sh_prio[best];
                end
            end
            ACT_REPORT: begin
                r = sh_running;
                sh_status[r] = c.status;
                if (c.status == ST_ZOMBIE) begin
                    sh_ticks[r] = '0;
                    sh_prio[r] = TOP_PRIO;
                end else begin
                    sum = {1'b0, sh_ticks[r]} + {1'b0, c.ticks};
                    sh_ticks[r] = sum[16] ? TICK_MAX : sum[15:0];
                end
                q = sh_quantum[sh_prio[r]];
                if (q == 0) q = 1;
                if (c.status != ST_SLEEPING && (sh_ticks[r] % q) == 0) sh_prev_pick = r;
                cand = sh_prev_pick;
                p = sh_prio[cand];
                if (p > 0 && sh_ticks[cand] >= sh_limit[p]) begin
                    sh_ticks[cand] = '0;
                    sh_prio[cand] = p - 2'd1;
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    sh_ticks[i] = '0;
                    sh_prio[i] = TOP_PRIO;
                end
            end
        endcase
        return g;
    endfunction

    function automatic sched_cmd_t mk(logic [1:0] a, logic [5:0] s, logic [2:0] st,
                                      logic f, logic [15:0] t);
        sched_cmd_t c;
        c.action = a;
        c.slot = s;
        c.status = st;
        c.fresh = f;
        c.ticks = t;
        return c;
    endfunction

    // Random transaction, biased toward runnable slots so dispatches find work.
    function automatic sched_cmd_t rand_cmd();
        sched_cmd_t c;
        int sel;
        sel = $urandom_range(0, 99);
        c.action = sel < 32 ? ACT_SET : sel < 62 ? ACT_DISPATCH : sel < 93 ? ACT_REPORT
                 : ACT_BOOST;
        c.slot = 6'($urandom_range(0, 63));
        c.status = $urandom_range(0, 2) == 0 ? 3'($urandom_range(0, 7)) : ST_RUNNABLE;
        if (c.action == ACT_REPORT && $urandom_range(0, 5) == 0) c.status = ST_ZOMBIE;
        c.fresh = 1'($urandom_range(0, 1));
        c.ticks = 16'($urandom_range(0, tick_cap));
        if (allow_huge && $urandom_range(0, 30) == 0) c.ticks = 16'($urandom);
        return c;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: offers queued transactions, idling in short random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                grant_queue.push_back(schedule_step({i_action, i_slot, i_new_status,
                                                     i_fresh, i_ticks_run}));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    send_gap <= $urandom_range(0, 2);
                    i_valid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    sched_cmd_t c;
                    c = cmd_queue.pop_front();
                    i_valid <= 1'b1;
                    {i_action, i_slot, i_new_status, i_fresh, i_ticks_run} <= c;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random bursts plus one long hold-off to back up the block.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
            hold_left <= 0;
            hold_done <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (!hold_done && accepted_cnt >= 120) begin
            hold_done <= 1;
            hold_left <= LONG_HOLD;
            i_stall <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap <= $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker: each transaction out is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (grant_queue.size() == 0) begin
                $error("result transaction with no prediction waiting");
                errors++;
            end else begin
                grant_t g;
                g = grant_queue.pop_front();
                if (o_granted !== g.granted) begin
                    $error("granted: expected %0d actual %0d", g.granted, o_granted);
                    errors++;
                end
                if (o_chosen_slot !== g.slot) begin
                    $error("chosen_slot: expected %0d actual %0d", g.slot, o_chosen_slot);
                    errors++;
                end
                if (o_chosen_priority !== g.prio) begin
                    $error("chosen_priority: expected %0d actual %0d", g.prio,
                           o_chosen_priority);
                    errors++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("mlfq_process_scheduler_top: mismatch");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= CFG_LIMIT_P3) sh_limit[idx + 1] = val;
        else sh_quantum[idx - CFG_QUANT_P0] = val;
    endtask

    task automatic program_all(logic [15:0] l1, logic [15:0] l2, logic [15:0] l3,
                               logic [15:0] q0, logic [15:0] q1, logic [15:0] q2,
                               logic [15:0] q3);
        write_reg(CFG_LIMIT_P1, l1);
        write_reg(CFG_LIMIT_P2, l2);
        write_reg(CFG_LIMIT_P3, l3);
        write_reg(CFG_QUANT_P0, q0);
        write_reg(CFG_QUANT_P1, q1);
        write_reg(CFG_QUANT_P2, q2);
        write_reg(CFG_QUANT_P3, q3);
    endtask

    task automatic drain();
        while (cmd_queue.size() > 0 || i_valid || grant_queue.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) cmd_queue.push_back(rand_cmd());
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_action = '0;
        i_slot = '0;
        i_new_status = '0;
        i_fresh = 0;
        i_ticks_run = '0;
        i_stall = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        errors = 0;
        cycle_cnt = 0;
        accepted_cnt = 0;
        quiet = 0;
        tick_cap = 40;
        allow_huge = 0;
        for (int i = 0; i < SLOTS; i++) begin
            sh_status[i] = '0;
            sh_prio[i] = TOP_PRIO;
            sh_ticks[i] = '0;
        end
        sh_prev_pick = 6'(SLOTS - 1);
        sh_running = '0;
        sh_limit = '{16'd0, 16'd32, 16'd16, 16'd8};
        sh_quantum = '{16'd32, 16'd8, 16'd4, 16'd2};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: report with no dispatch, empty dispatch, extremes and specials.
        cmd_queue.push_back(mk(ACT_REPORT, 6'd0, ST_SLEEPING, 1'b0, 16'd3));
        cmd_queue.push_back(mk(ACT_DISPATCH, 6'd0, 3'd0, 1'b0, 16'd0));
        cmd_queue.push_back(mk(ACT_SET, 6'd63, ST_RUNNABLE, 1'b1, 16'hFFFF));
        cmd_queue.push_back(mk(ACT_DISPATCH, 6'd0, 3'd0, 1'b0, 16'd0));
        cmd_queue.push_back(mk(ACT_DISPATCH, 6'd0, 3'd0, 1'b0, 16'd0));
        cmd_queue.push_back(mk(ACT_REPORT, 6'd0, ST_RUNNABLE, 1'b0, 16'd2));
        cmd_queue.push_back(mk(ACT_DISPATCH, 6'd0, 3'd0, 1'b0, 16'd0));
        cmd_queue.push_back(mk(ACT_SET, 6'd0, ST_RUNNABLE, 1'b1, 16'd0));
        cmd_queue.push_back(mk(ACT_SET, 6'd21, 3'd7, 1'b0, 16'd0));
        cmd_queue.push_back(mk(ACT_SET, 6'd42, 3'd6, 1'b1, 16'd0));
        cmd_queue.push_back(mk(ACT_REPORT, 6'd0, ST_RUNNABLE, 1'b0, 16'hFFFF));
        cmd_queue.push_back(mk(ACT_REPORT, 6'd0, ST_RUNNABLE, 1'b0, 16'hFFFF));
        cmd_queue.push_back(mk(ACT_DISPATCH, 6'd0, 3'd0, 1'b0, 16'd0));
        cmd_queue.push_back(mk(ACT_REPORT, 6'd0, ST_ZOMBIE, 1'b0, 16'd9));
        cmd_queue.push_back(mk(ACT_DISPATCH, 6'd0, 3'd0, 1'b0, 16'd0));
        cmd_queue.push_back(mk(ACT_REPORT, 6'd0, ST_SLEEPING, 1'b0, 16'd8));
        cmd_queue.push_back(mk(ACT_BOOST, 6'd0, 3'd0, 1'b0, 16'd0));
        cmd_queue.push_back(mk(ACT_DISPATCH, 6'd0, 3'd0, 1'b0, 16'd0));
        cmd_queue.push_back(mk(ACT_REPORT, 6'd0, ST_RUNNING, 1'b1, 16'd1));
        cmd_queue.push_back(mk(ACT_SET, 6'd63, 3'd0, 1'b0, 16'd0));
        cmd_queue.push_back(mk(ACT_DISPATCH, 6'd0, 3'd0, 1'b0, 16'd0));
        drain();

        random_phase(300);

        // Smallest limits and quanta: demotion and rotation at the lowest thresholds.
        program_all(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        tick_cap = 7;
        random_phase(300);

        // Largest settings: huge tick counts, with the remainder taken by the largest quantum.
        program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tick_cap = 200;
        allow_huge = 1;
        random_phase(150);

        // Mixed mid-range settings.
        allow_huge = 0;
        tick_cap = 40;
        program_all(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)),
                    16'($urandom_range(1, 64)), 16'($urandom_range(1, 16)),
                    16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)),
                    16'($urandom_range(1, 16)));
        random_phase(250);

        // Back to the reset values, with no idling at either side.
        program_all(16'd32, 16'd16, 16'd8, 16'd32, 16'd8, 16'd4, 16'd2);
        quiet = 1;
        random_phase(250);

        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("mlfq_process_scheduler_top: match");
        end else begin
            $display("mlfq_process_scheduler_top: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/mlfq_pkg.sv
rtl/core/mlfq_front.sv
rtl/core/mlfq_back.sv
rtl/core/mlfq_process_scheduler_top.sv
rtl/core/mlfq_checker.sv
test/tb_mlfq_process_scheduler_top.sv
